// File: src/cbe_pkg.sv
// shared constants, types and helpers for the cubic bezier easing unit
`default_nettype none

package cbe_pkg;

	// default configuration
	localparam int FRAC_BITS_DEF    = 16;
	localparam int NEWTON_STEPS_DEF = 6;

	// fixed field widths
	localparam int MODE_W = 3;
	localparam int VAL_W  = 18;

	// output saturation limits
	localparam int OUT_MAX = 131071;
	localparam int OUT_MIN = -131072;

	// easing mode codes, anything above spring is ease-out cubic
	localparam logic [MODE_W-1:0] MODE_LINEAR   = 3'd0;
	localparam logic [MODE_W-1:0] MODE_STANDARD = 3'd1;
	localparam logic [MODE_W-1:0] MODE_SWIFT    = 3'd2;
	localparam logic [MODE_W-1:0] MODE_SPRING   = 3'd3;

	// control points in hundredths
	localparam int STD_X1 = 25;
	localparam int STD_Y1 = 10;
	localparam int STD_X2 = 25;
	localparam int SWF_X1 = 16;
	localparam int SWF_Y1 = 100;
	localparam int SWF_X2 = 30;
	localparam int SPR_X1 = 34;
	localparam int SPR_Y1 = 156;
	localparam int SPR_X2 = 64;
	localparam int ALL_Y2 = 100;

	// control bits that travel with every item
	typedef struct packed {
		logic              valid;
		logic              done;
		logic [MODE_W-1:0] mode;
	} cbe_ctl_t;

	// internal datapath width: sign, integer headroom and fraction
	function automatic int fx_width(input int frac);
		return frac + 6;
	endfunction

	// constant in hundredths, rounded to nearest
	function automatic longint fx_const(input int hundredths, input int frac);
		return ((longint'(1) <<< frac) * hundredths + 50) / 100;
	endfunction

	// derivative threshold, at least one lsb
	function automatic longint fx_eps(input int frac);
		longint e;
		e = ((longint'(1) <<< frac) + 5000) / 10000;
		return (e > 0) ? e : 1;
	endfunction

	function automatic logic is_bezier(input logic [MODE_W-1:0] m);
		return (m == MODE_STANDARD) || (m == MODE_SWIFT) || (m == MODE_SPRING);
	endfunction

endpackage

`default_nettype wire

// File: src/cbe_in_if.sv
// input channel: easing mode and progress
`default_nettype none

interface cbe_in_if
	import cbe_pkg::*;
();
	logic                    valid;
	logic                    ready;
	logic [MODE_W-1:0]       easing_mode;
	logic signed [VAL_W-1:0] progress_in;

	modport source (output valid, output easing_mode, output progress_in, input ready);
	modport sink   (input valid, input easing_mode, input progress_in, output ready);
endinterface

`default_nettype wire

// File: src/cbe_out_if.sv
// output channel: eased value
`default_nettype none

interface cbe_out_if
	import cbe_pkg::*;
();
	logic                    valid;
	logic                    ready;
	logic signed [VAL_W-1:0] eased_value;

	modport source (output valid, output eased_value, input ready);
	modport sink   (input valid, input eased_value, output ready);
endinterface

`default_nettype wire

// File: src/cubic_bezier_easing_unit.sv
// top level: input clamp, chain of newton steps, output evaluation
//
//  channel | dir | fields                          | handshake
//  req     | in  | easing_mode[2:0], progress_in   | valid/ready
//  rsp     | out | eased_value[17:0]               | valid/ready
//
// one item enters per cycle while the output is not stalled; the pipeline length is set
// mostly by the one-bit-per-stage divider in each newton step
// reset clears the control bits (valid, done, mode) only; data registers carry no reset
// a stalled output freezes the whole pipeline; nothing is lost or repeated
`default_nettype none

module cubic_bezier_easing_unit
	import cbe_pkg::*;
#(
	parameter int FRAC_BITS    = FRAC_BITS_DEF,
	parameter int NEWTON_STEPS = NEWTON_STEPS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	cbe_in_if.sink   req,
	cbe_out_if.source rsp
);
	localparam int W  = fx_width(FRAC_BITS);
	localparam int CW = ((W > VAL_W) ? W : VAL_W) + 1;

	localparam logic signed [W-1:0] ONE = W'(longint'(1) <<< FRAC_BITS);

	logic                 en;
	logic signed [CW-1:0] pin_ext;
	logic signed [W-1:0]  p_clamp;
	logic signed [W-1:0]  p_s0;
	cbe_ctl_t             ctl_in;
	cbe_ctl_t             ctl_s0;

	cbe_ctl_t            chain_ctl [0:NEWTON_STEPS];
	logic signed [W-1:0] chain_p   [0:NEWTON_STEPS];
	logic signed [W-1:0] chain_t   [0:NEWTON_STEPS];

	// whole pipeline advances unless a result is held at the output
	assign en        = !rsp.valid || rsp.ready;
	assign req.ready = en;

	// clamp progress to [0, one]
	always_comb begin
		pin_ext = {{(CW-VAL_W){req.progress_in[VAL_W-1]}}, req.progress_in};
		if (pin_ext < 0) begin
			p_clamp = '0;
		end else if (pin_ext > CW'(ONE)) begin
			p_clamp = ONE;
		end else begin
			p_clamp = W'(pin_ext);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s0 <= p_clamp;
		end
	end

	// entry control: non-bezier modes skip the newton steps
	always_comb begin
		ctl_in.valid = req.valid;
		ctl_in.done  = !is_bezier(req.easing_mode);
		ctl_in.mode  = req.easing_mode;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s0 <= '0;
		end else if (en) begin
			ctl_s0 <= ctl_in;
		end
	end

	assign chain_ctl[0] = ctl_s0;
	assign chain_p[0]   = p_s0;
	assign chain_t[0]   = p_s0;

	// newton steps in series
	for (genvar i = 0; i < NEWTON_STEPS; i++) begin : g_step
		cbe_newton_step #(.FRAC_BITS(FRAC_BITS)) u_step (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.ctl_i  (chain_ctl[i]),
			.p_i    (chain_p[i]),
			.t_i    (chain_t[i]),
			.ctl_o  (chain_ctl[i+1]),
			.p_o    (chain_p[i+1]),
			.t_o    (chain_t[i+1])
		);
	end

	cbe_eval_out #(.FRAC_BITS(FRAC_BITS)) u_eval (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.ctl_i   (chain_ctl[NEWTON_STEPS]),
		.p_i     (chain_p[NEWTON_STEPS]),
		.t_i     (chain_t[NEWTON_STEPS]),
		.valid_o (rsp.valid),
		.value_o (rsp.eased_value)
	);

	// a held result blocks new items
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.ready) |-> !req.ready)
		else $error("input taken while output stalled");

	// clamped progress stays in [0, one]
	a_entry_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_s0.valid |-> (p_s0 >= 0) && (p_s0 <= ONE))
		else $error("entry progress out of range");
endmodule

`default_nettype wire

// File: src/cbe_fxmul.sv
// signed fixed point multiply, rounded to nearest with ties away from zero
`default_nettype none

module cbe_fxmul #(
	parameter int W = 22,
	parameter int F = 16
) (
	input  logic signed [W-1:0] a,
	input  logic signed [W-1:0] b,
	output logic signed [W-1:0] p
);
	logic [W-1:0]   ma;
	logic [W-1:0]   mb;
	logic [2*W-1:0] prod;
	logic [2*W-1:0] rnd;
	logic [W-1:0]   pm;
	logic           neg;

	// work on magnitudes, round, then restore the sign
	assign ma   = a[W-1] ? ($unsigned(~a) + W'(1)) : $unsigned(a);
	assign mb   = b[W-1] ? ($unsigned(~b) + W'(1)) : $unsigned(b);
	assign neg  = a[W-1] ^ b[W-1];
	assign prod = (2*W)'(ma) * (2*W)'(mb);
	assign rnd  = prod + ((2*W)'(1) << (F - 1));
	assign pm   = W'(rnd >> F);
	assign p    = neg ? -$signed(pm) : $signed(pm);
endmodule

`default_nettype wire

// File: src/cbe_newton_step.sv
// one newton step on x(t)=p: polynomial stages, bit-serial divider stages, update
`default_nettype none

module cbe_newton_step
	import cbe_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  en,
	input  cbe_ctl_t                              ctl_i,
	input  logic signed [fx_width(FRAC_BITS)-1:0] p_i,
	input  logic signed [fx_width(FRAC_BITS)-1:0] t_i,
	output cbe_ctl_t                              ctl_o,
	output logic signed [fx_width(FRAC_BITS)-1:0] p_o,
	output logic signed [fx_width(FRAC_BITS)-1:0] t_o
);
	localparam int W  = fx_width(FRAC_BITS);
	localparam int NW = W + FRAC_BITS + 1;
	localparam int TW = NW + 2;

	localparam logic signed [W-1:0] ONE    = W'(longint'(1) <<< FRAC_BITS);
	localparam logic [W-1:0]        EPS    = W'(fx_eps(FRAC_BITS));
	localparam logic signed [W-1:0] STD_C1 = W'(fx_const(STD_X1, FRAC_BITS));
	localparam logic signed [W-1:0] STD_C2 = W'(fx_const(STD_X2, FRAC_BITS));
	localparam logic signed [W-1:0] SWF_C1 = W'(fx_const(SWF_X1, FRAC_BITS));
	localparam logic signed [W-1:0] SWF_C2 = W'(fx_const(SWF_X2, FRAC_BITS));
	localparam logic signed [W-1:0] SPR_C1 = W'(fx_const(SPR_X1, FRAC_BITS));
	localparam logic signed [W-1:0] SPR_C2 = W'(fx_const(SPR_X2, FRAC_BITS));

	// stage 1 signals
	logic signed [W-1:0] s_c, c1_a, c2_a;
	logic signed [W-1:0] ss_c, st_c, tt_c, tc1_c, tc2_c;
	logic signed [W-1:0] ss_s1, st_s1, tt_s1, tc1_s1, tc2_s1, t_s1, p_s1;
	cbe_ctl_t            ctl_s1;

	// stage 2 signals
	logic signed [W-1:0] c1_b, c2_b, dc_b, oc_b;
	logic signed [W-1:0] ma_c, mb_c, mc_c, md_c, me_c, mf_c;
	logic signed [W-1:0] ma_s2, mb_s2, mc_s2, md_s2, me_s2, mf_s2, t_s2, p_s2;
	cbe_ctl_t            ctl_s2;

	// stage 3 signals
	logic signed [W-1:0] x_c, d_c, a_c;
	logic [W-1:0]        abs_a, abs_d;
	logic [NW-1:0]       num_c;
	cbe_ctl_t            ctl_chk;

	// divider stages, index is the stage
	logic [NW-1:0]       div_nq_s  [0:NW];
	logic [W-1:0]        div_rem_s [0:NW];
	logic [W-1:0]        div_dv_s  [0:NW];
	logic                div_neg_s [0:NW];
	logic signed [W-1:0] div_t_s   [0:NW];
	logic signed [W-1:0] div_p_s   [0:NW];
	cbe_ctl_t            div_ctl_s [0:NW];

	// update stage signals
	logic signed [TW-1:0] t_ext, q_ext, tn_c;
	logic signed [W-1:0]  t_new;
	logic signed [W-1:0]  t_s4, p_s4;
	cbe_ctl_t             ctl_s4;

	// stage 1: powers of t and s, t times control points
	always_comb begin
		s_c = ONE - t_i;
		case (ctl_i.mode)
			MODE_STANDARD: begin c1_a = STD_C1; c2_a = STD_C2; end
			MODE_SWIFT:    begin c1_a = SWF_C1; c2_a = SWF_C2; end
			MODE_SPRING:   begin c1_a = SPR_C1; c2_a = SPR_C2; end
			default:       begin c1_a = STD_C1; c2_a = STD_C2; end
		endcase
	end

	cbe_fxmul #(.W(W), .F(FRAC_BITS)) u_ss  (.a(s_c), .b(s_c),  .p(ss_c));
	cbe_fxmul #(.W(W), .F(FRAC_BITS)) u_st  (.a(s_c), .b(t_i),  .p(st_c));
	cbe_fxmul #(.W(W), .F(FRAC_BITS)) u_tt  (.a(t_i), .b(t_i),  .p(tt_c));
	cbe_fxmul #(.W(W), .F(FRAC_BITS)) u_tc1 (.a(t_i), .b(c1_a), .p(tc1_c));
	cbe_fxmul #(.W(W), .F(FRAC_BITS)) u_tc2 (.a(t_i), .b(c2_a), .p(tc2_c));

	always_ff @(posedge clk) begin
		if (en) begin
			ss_s1  <= ss_c;
			st_s1  <= st_c;
			tt_s1  <= tt_c;
			tc1_s1 <= tc1_c;
			tc2_s1 <= tc2_c;
			t_s1   <= t_i;
			p_s1   <= p_i;
		end
	end

	// stage 2: second level products for x(t) and x'(t)
	always_comb begin
		case (ctl_s1.mode)
			MODE_STANDARD: begin c1_b = STD_C1; c2_b = STD_C2; end
			MODE_SWIFT:    begin c1_b = SWF_C1; c2_b = SWF_C2; end
			MODE_SPRING:   begin c1_b = SPR_C1; c2_b = SPR_C2; end
			default:       begin c1_b = STD_C1; c2_b = STD_C2; end
		endcase
		dc_b = c2_b - c1_b;
		oc_b = ONE - c2_b;
	end

	cbe_fxmul #(.W(W), .F(FRAC_BITS)) u_ma (.a(ss_s1), .b(tc1_s1), .p(ma_c));
	cbe_fxmul #(.W(W), .F(FRAC_BITS)) u_mb (.a(st_s1), .b(tc2_s1), .p(mb_c));
	cbe_fxmul #(.W(W), .F(FRAC_BITS)) u_mc (.a(tt_s1), .b(t_s1),   .p(mc_c));
	cbe_fxmul #(.W(W), .F(FRAC_BITS)) u_md (.a(ss_s1), .b(c1_b),   .p(md_c));
	cbe_fxmul #(.W(W), .F(FRAC_BITS)) u_me (.a(st_s1), .b(dc_b),   .p(me_c));
	cbe_fxmul #(.W(W), .F(FRAC_BITS)) u_mf (.a(tt_s1), .b(oc_b),   .p(mf_c));

	always_ff @(posedge clk) begin
		if (en) begin
			ma_s2 <= ma_c;
			mb_s2 <= mb_c;
			mc_s2 <= mc_c;
			md_s2 <= md_c;
			me_s2 <= me_c;
			mf_s2 <= mf_c;
			t_s2  <= t_s1;
			p_s2  <= p_s1;
		end
	end

	// stage 3: sums, residual, divider operands, flat slope check
	always_comb begin
		x_c   = W'(3) * ma_s2 + W'(3) * mb_s2 + mc_s2;
		d_c   = W'(3) * md_s2 + W'(6) * me_s2 + W'(3) * mf_s2;
		a_c   = x_c - p_s2;
		abs_a = a_c[W-1] ? ($unsigned(~a_c) + W'(1)) : $unsigned(a_c);
		abs_d = d_c[W-1] ? ($unsigned(~d_c) + W'(1)) : $unsigned(d_c);
		num_c = (NW'(abs_a) << FRAC_BITS) + NW'(abs_d >> 1);
	end

	// a flat slope ends the newton steps for this item
	always_comb begin
		ctl_chk      = ctl_s2;
		ctl_chk.done = ctl_s2.done | (abs_d < EPS);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			div_nq_s[0]  <= num_c;
			div_rem_s[0] <= '0;
			div_dv_s[0]  <= abs_d;
			div_neg_s[0] <= a_c[W-1] ^ d_c[W-1];
			div_t_s[0]   <= t_s2;
			div_p_s[0]   <= p_s2;
		end
	end

	// control through the polynomial stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1       <= '0;
			ctl_s2       <= '0;
			div_ctl_s[0] <= '0;
		end else if (en) begin
			ctl_s1       <= ctl_i;
			ctl_s2       <= ctl_s1;
			div_ctl_s[0] <= ctl_chk;
		end
	end

	// restoring divider, one quotient bit per stage
	for (genvar k = 0; k < NW; k++) begin : g_div
		logic [W:0] rx;
		logic       ge;

		assign rx = {div_rem_s[k], div_nq_s[k][NW-1]};
		assign ge = rx >= {1'b0, div_dv_s[k]};

		always_ff @(posedge clk) begin
			if (en) begin
				div_nq_s[k+1]  <= {div_nq_s[k][NW-2:0], ge};
				div_rem_s[k+1] <= ge ? W'(rx - {1'b0, div_dv_s[k]}) : W'(rx);
				div_dv_s[k+1]  <= div_dv_s[k];
				div_neg_s[k+1] <= div_neg_s[k];
				div_t_s[k+1]   <= div_t_s[k];
				div_p_s[k+1]   <= div_p_s[k];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_ctl_s[k+1] <= '0;
			end else if (en) begin
				div_ctl_s[k+1] <= div_ctl_s[k];
			end
		end
	end

	// update: step t by the quotient and clamp to [0, one]; a done item keeps its t
	always_comb begin
		t_ext = {{(TW-W){div_t_s[NW][W-1]}}, div_t_s[NW]};
		q_ext = $signed({2'b00, div_nq_s[NW]});
		tn_c  = div_neg_s[NW] ? (t_ext + q_ext) : (t_ext - q_ext);
		if (div_ctl_s[NW].done) begin
			t_new = div_t_s[NW];
		end else if (tn_c < 0) begin
			t_new = '0;
		end else if (tn_c > TW'(ONE)) begin
			t_new = ONE;
		end else begin
			t_new = W'(tn_c);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s4 <= t_new;
			p_s4 <= div_p_s[NW];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s4 <= '0;
		end else if (en) begin
			ctl_s4 <= div_ctl_s[NW];
		end
	end

	assign ctl_o = ctl_s4;
	assign p_o   = p_s4;
	assign t_o   = t_s4;

	// t leaves every step inside [0, one]
	a_t_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_s4.valid |-> (t_s4 >= 0) && (t_s4 <= ONE))
		else $error("newton step t out of range");

	// a flat slope stays flat for the rest of the item
	a_done_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(en && ctl_s2.valid && ctl_s2.done) |=> div_ctl_s[0].done)
		else $error("done flag dropped");
endmodule

`default_nettype wire

// File: src/cbe_eval_out.sv
// final curve evaluation y(t), ease-out cubic, linear pick and saturation
`default_nettype none

module cbe_eval_out
	import cbe_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  en,
	input  cbe_ctl_t                              ctl_i,
	input  logic signed [fx_width(FRAC_BITS)-1:0] p_i,
	input  logic signed [fx_width(FRAC_BITS)-1:0] t_i,
	output logic                                  valid_o,
	output logic signed [VAL_W-1:0]               value_o
);
	localparam int W  = fx_width(FRAC_BITS);
	localparam int VW = ((W > VAL_W) ? W : VAL_W) + 1;

	localparam logic signed [W-1:0] ONE    = W'(longint'(1) <<< FRAC_BITS);
	localparam logic signed [W-1:0] STD_C1 = W'(fx_const(STD_Y1, FRAC_BITS));
	localparam logic signed [W-1:0] SWF_C1 = W'(fx_const(SWF_Y1, FRAC_BITS));
	localparam logic signed [W-1:0] SPR_C1 = W'(fx_const(SPR_Y1, FRAC_BITS));
	localparam logic signed [W-1:0] C2     = W'(fx_const(ALL_Y2, FRAC_BITS));

	logic signed [W-1:0] s_c, r_c, c1_a;
	logic signed [W-1:0] ss_c, st_c, tt_c, tc1_c, tc2_c, rr_c;
	logic signed [W-1:0] ss_s1, st_s1, tt_s1, tc1_s1, tc2_s1, rr_s1, r_s1, t_s1, p_s1;
	cbe_ctl_t            ctl_s1;
	logic signed [W-1:0] ma_c, mb_c, mc_c, mr_c;
	logic signed [W-1:0] ma_s2, mb_s2, mc_s2, mr_s2, p_s2;
	cbe_ctl_t            ctl_s2;
	logic signed [W-1:0] v_c;
	logic signed [VW-1:0] v_ext;
	logic signed [VAL_W-1:0] sat_c;
	logic signed [VAL_W-1:0] value_s3;
	cbe_ctl_t            ctl_s3;

	// stage 1: powers of t, s and r, t times y control points
	always_comb begin
		s_c = ONE - t_i;
		r_c = ONE - p_i;
		case (ctl_i.mode)
			MODE_STANDARD: c1_a = STD_C1;
			MODE_SWIFT:    c1_a = SWF_C1;
			MODE_SPRING:   c1_a = SPR_C1;
			default:       c1_a = STD_C1;
		endcase
	end

	cbe_fxmul #(.W(W), .F(FRAC_BITS)) u_ss  (.a(s_c), .b(s_c),  .p(ss_c));
	cbe_fxmul #(.W(W), .F(FRAC_BITS)) u_st  (.a(s_c), .b(t_i),  .p(st_c));
	cbe_fxmul #(.W(W), .F(FRAC_BITS)) u_tt  (.a(t_i), .b(t_i),  .p(tt_c));
	cbe_fxmul #(.W(W), .F(FRAC_BITS)) u_tc1 (.a(t_i), .b(c1_a), .p(tc1_c));
	cbe_fxmul #(.W(W), .F(FRAC_BITS)) u_tc2 (.a(t_i), .b(C2),   .p(tc2_c));
	cbe_fxmul #(.W(W), .F(FRAC_BITS)) u_rr  (.a(r_c), .b(r_c),  .p(rr_c));

	always_ff @(posedge clk) begin
		if (en) begin
			ss_s1  <= ss_c;
			st_s1  <= st_c;
			tt_s1  <= tt_c;
			tc1_s1 <= tc1_c;
			tc2_s1 <= tc2_c;
			rr_s1  <= rr_c;
			r_s1   <= r_c;
			t_s1   <= t_i;
			p_s1   <= p_i;
		end
	end

	// stage 2: second level products
	cbe_fxmul #(.W(W), .F(FRAC_BITS)) u_ma (.a(ss_s1), .b(tc1_s1), .p(ma_c));
	cbe_fxmul #(.W(W), .F(FRAC_BITS)) u_mb (.a(st_s1), .b(tc2_s1), .p(mb_c));
	cbe_fxmul #(.W(W), .F(FRAC_BITS)) u_mc (.a(tt_s1), .b(t_s1),   .p(mc_c));
	cbe_fxmul #(.W(W), .F(FRAC_BITS)) u_mr (.a(rr_s1), .b(r_s1),   .p(mr_c));

	always_ff @(posedge clk) begin
		if (en) begin
			ma_s2 <= ma_c;
			mb_s2 <= mb_c;
			mc_s2 <= mc_c;
			mr_s2 <= mr_c;
			p_s2  <= p_s1;
		end
	end

	// stage 3: pick the result by mode and saturate to the output range
	always_comb begin
		if (ctl_s2.mode == MODE_LINEAR) begin
			v_c = p_s2;
		end else if (is_bezier(ctl_s2.mode)) begin
			v_c = W'(3) * ma_s2 + W'(3) * mb_s2 + mc_s2;
		end else begin
			v_c = ONE - mr_s2;
		end
		v_ext = {{(VW-W){v_c[W-1]}}, v_c};
		if (v_ext > VW'(OUT_MAX)) begin
			sat_c = VAL_W'(OUT_MAX);
		end else if (v_ext < VW'(OUT_MIN)) begin
			sat_c = VAL_W'(OUT_MIN);
		end else begin
			sat_c = VAL_W'(v_ext);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			value_s3 <= sat_c;
		end
	end

	// control through the output stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl_i;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
		end
	end

	assign valid_o = ctl_s3.valid;
	assign value_o = value_s3;

	// ease-out cubic results stay in [0, one]
	a_ease_range: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl_s3.valid && (ctl_s3.mode != MODE_LINEAR) && !is_bezier(ctl_s3.mode))
		|-> (value_s3 >= 0) && (VW'(value_s3) <= VW'(ONE)))
		else $error("ease-out result out of range");
endmodule

`default_nettype wire

// File: verif/cbe_checker.sv
// checker for the cubic bezier easing unit: predicts eased values and compares
`timescale 1ns / 100ps
`default_nettype none

module cbe_checker
	import cbe_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	cbe_in_if.sink    req_mon,
	cbe_out_if.sink   rsp_mon,
	output int        fail_count,
	output int        pending
);

	localparam int  FB  = FRAC_BITS_DEF;
	localparam longint ONE = longint'(1) <<< FB;

	logic signed [VAL_W-1:0] eased_q[$];

	assign pending = eased_q.size();

	function automatic longint hund(input int h);
		return (ONE * h + 50) / 100;
	endfunction

	// rounded fixed-point product, ties away from zero on magnitudes
	function automatic longint fmul(input longint a, input longint b);
		longint m;
		m = (a < 0 ? -a : a) * (b < 0 ? -b : b);
		m = (m + (longint'(1) <<< (FB - 1))) >>> FB;
		return ((a < 0) != (b < 0)) ? -m : m;
	endfunction

	function automatic longint fdiv(input longint a, input longint b);
		longint ma, mb, q;
		ma = a < 0 ? -a : a;
		mb = b < 0 ? -b : b;
		if (mb == 0)
			return 0;
		q = ((ma <<< FB) + mb / 2) / mb;
		return ((a < 0) != (b < 0)) ? -q : q;
	endfunction

	function automatic longint bez(input longint c1, input longint c2, input longint t);
		longint s;
		s = ONE - t;
		return 3 * fmul(fmul(s, s), fmul(t, c1)) + 3 * fmul(fmul(s, t), fmul(t, c2))
			+ fmul(fmul(t, t), t);
	endfunction

	function automatic longint bez_slope(input longint c1, input longint c2, input longint t);
		longint s;
		s = ONE - t;
		return 3 * fmul(fmul(s, s), c1) + 6 * fmul(fmul(s, t), c2 - c1)
			+ 3 * fmul(fmul(t, t), ONE - c2);
	endfunction

	// newton solve for t with x(t) = p, then y(t)
	function automatic longint solve_curve(input longint p, input int x1, input int y1,
			input int x2);
		longint t, d, eps;
		t = p;
		eps = (ONE + 5000) / 10000;
		if (eps < 1)
			eps = 1;
		for (int i = 0; i < NEWTON_STEPS_DEF; i++) begin
			d = bez_slope(hund(x1), hund(x2), t);
			if ((d < 0 ? -d : d) < eps)
				break;
			t = t - fdiv(bez(hund(x1), hund(x2), t) - p, d);
			if (t < 0)
				t = 0;
			if (t > ONE)
				t = ONE;
		end
		return bez(hund(y1), hund(ALL_Y2), t);
	endfunction

	function automatic logic signed [VAL_W-1:0] eased_of(input logic [MODE_W-1:0] m,
			input logic signed [VAL_W-1:0] prog);
		longint p, v, r;
		p = prog;
		if (p < 0)
			p = 0;
		if (p > ONE)
			p = ONE;
		case (m)
			MODE_LINEAR:   v = p;
			MODE_STANDARD: v = solve_curve(p, STD_X1, STD_Y1, STD_X2);
			MODE_SWIFT:    v = solve_curve(p, SWF_X1, SWF_Y1, SWF_X2);
			MODE_SPRING:   v = solve_curve(p, SPR_X1, SPR_Y1, SPR_X2);
			default: begin
				r = ONE - p;
				v = ONE - fmul(fmul(r, r), r);
			end
		endcase
		if (v > OUT_MAX)
			v = OUT_MAX;
		if (v < OUT_MIN)
			v = OUT_MIN;
		return v[VAL_W-1:0];
	endfunction

	// watch both channels on every edge
	always @(posedge clk or negedge arst_n) begin
		logic signed [VAL_W-1:0] want;
		if (!arst_n) begin
			fail_count <= 0;
		end else begin
			if (req_mon.valid && req_mon.ready)
				eased_q.push_back(eased_of(req_mon.easing_mode, req_mon.progress_in));
			if (rsp_mon.valid && rsp_mon.ready) begin
				if (eased_q.size() == 0) begin
					$display("%0t: unexpected eased value %0d", $time, rsp_mon.eased_value);
					fail_count <= fail_count + 1;
				end else begin
					want = eased_q.pop_front();
					if (want !== rsp_mon.eased_value) begin
						$display("%0t: eased value expected %0d actual %0d", $time, want,
							rsp_mon.eased_value);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end

endmodule

`default_nettype wire

// File: verif/tb.sv
// testbench top for the cubic bezier easing unit: stimulus, stalls and verdict
`timescale 1ns / 100ps
`default_nettype none

module tb
	import cbe_pkg::*;
();

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending;
	int   sent;
	logic calm;

	cbe_in_if  req();
	cbe_out_if rsp();

	cubic_bezier_easing_unit uut (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));
	cbe_checker chk (.clk(clk), .arst_n(arst_n), .req_mon(req), .rsp_mon(rsp),
		.fail_count(fail_count), .pending(pending));

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("simulation failed");
		$finish;
	end

	// directed items: every mode at the progress extremes and a few inside
	localparam int N_DIR = 24;
	logic [MODE_W-1:0]       dir_mode[N_DIR];
	logic signed [VAL_W-1:0] dir_prog[N_DIR];
	initial begin
		for (int i = 0; i < N_DIR; i++) begin
			dir_mode[i] = 3'(i % 8);
			case (i / 8)
				0: dir_prog[i] = -18'sd131072;
				1: dir_prog[i] = 18'sd65536;
				default: dir_prog[i] = (i % 2) ? 18'sd131071 : 18'sd32768;
			endcase
		end
		dir_prog[3] = 18'sd0;
		dir_prog[11] = 18'sd1;
		dir_prog[19] = 18'sd65537;
	end

	// receiver: random stall bursts, one long hold-off, calm at the end
	initial begin
		rsp.ready <= 1'b0;
		@(posedge arst_n);
		repeat (300) @(posedge clk);
		rsp.ready <= 1'b0;
		repeat (600) @(posedge clk);
		forever begin
			@(posedge clk);
			if (!calm && $urandom_range(0, 5) == 0) begin
				rsp.ready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
			end
			rsp.ready <= 1'b1;
		end
	end

	// sender
	initial begin
		logic [MODE_W-1:0]       m;
		logic signed [VAL_W-1:0] p;
		int                      n;
		calm = 1'b0;
		arst_n = 1'b0;
		req.valid <= 1'b0;
		req.easing_mode <= '0;
		req.progress_in <= '0;
		sent = 0;
		repeat (12) @(posedge clk);
		arst_n = 1'b1;
		n = N_DIR + 1100;
		while (sent < n) begin
			if (sent >= n - 150)
				calm = 1'b1;
			if (sent < N_DIR) begin
				m = dir_mode[sent];
				p = dir_prog[sent];
			end else begin
				m = 3'($urandom_range(0, 7));
				case ($urandom_range(0, 9))
					0: p = 18'($urandom);
					1: p = 18'($urandom_range(65530, 65536));
					2: p = 18'($urandom_range(0, 8));
					default: p = 18'($urandom_range(0, 65536));
				endcase
			end
			if (!calm && $urandom_range(0, 5) == 0) begin
				req.valid <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
			end
			req.valid <= 1'b1;
			req.easing_mode <= m;
			req.progress_in <= p;
			@(posedge clk);
			while (!req.ready)
				@(posedge clk);
			sent++;
		end
		req.valid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

`default_nettype wire

// File: files.f
src/cbe_pkg.sv
src/cbe_in_if.sv
src/cbe_out_if.sv
src/cbe_fxmul.sv
src/cbe_newton_step.sv
src/cbe_eval_out.sv
src/cubic_bezier_easing_unit.sv
verif/cbe_checker.sv
verif/tb.sv
